FILE: hw/rtl/bbsf_pkg.sv
// ----------------------------------------------------------------------------
// bbsf_pkg - shared definitions for the bounded byte stream FIFO
// Ring depth, derived widths, operation codes and beat layouts.
// ----------------------------------------------------------------------------
package bbsf_pkg;

    // Ring depth in bytes (any value from 2 to 65536).
    localparam int DEPTH = 1024;

    // Derived widths.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the stream beats.
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int FCNT_W   = 11;
    localparam int TOTAL_W  = 64;

    // Width that holds both a count field and a held count, plus one bit so
    // that a pointer plus a count never overflows.
    localparam int CMP_W = ((CNT_W > FCNT_W) ? CNT_W : FCNT_W) + 1;

    // Beat layouts.
    localparam int S_DATA_W   = 24;
    localparam int M_FIELDS_W = BYTE_W + 1 + FCNT_W + FCNT_W + TOTAL_W + TOTAL_W + 3;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Capacity register reset value.
    localparam logic [FCNT_W-1:0] CAP_RESET = FCNT_W'(1024);

    // Operation codes carried in s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [TOTAL_W-1:0] total_t;

endpackage

FILE: hw/rtl/bounded_byte_stream_fifo.sv
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo - byte FIFO with capacity limit and writer close
// Timing: the input beat is taken in IDLE, the ring read data arrives in LOAD,
// and the result beat is then registered once the output register is free.
// Flow: s_tready is low in LOAD, so no new input beat is taken until the result
// beat of the last one has been loaded; the ring RAM's registered read is why.
// Reset: control state, pointers, totals and flags clear; capacity becomes 1024.
// The ring contents stay undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Capacity register write port.
    input  logic                         cfg_wr_en,
    input  logic [bbsf_pkg::FCNT_W-1:0]  cfg_wr_data,
    // Input beats.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: push_byte [7:0], pop_count [18:8], zero [23:19]
    input  logic [bbsf_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: func [1:0]
    input  logic [bbsf_pkg::FUNC_W-1:0]  s_tuser,
    // Result beats.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: front_byte [7:0], front_valid [8], buffered_count [19:9],
    // free_space [30:20], total_pushed [94:31], total_popped [158:95],
    // closed_flag [159], finished_flag [160], error_flag [161], zero [167:162]
    output logic [bbsf_pkg::M_DATA_W-1:0] m_tdata
);

    import bbsf_pkg::*;

    // The sequencer has two states. In IDLE an input beat is taken, the
    // FIFO state is updated and the ring is read at the new read pointer.
    // In LOAD the read data has arrived and the result beat is built into
    // the output register as soon as that register is free.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic                 state_reg, state_next;
    logic [FCNT_W-1:0]    cap_reg;
    ptr_t                 rd_ptr_reg, rd_ptr_next;
    ptr_t                 wr_ptr_reg, wr_ptr_next;
    cnt_t                 held_reg, held_next;
    total_t               pushed_reg, pushed_next;
    total_t               popped_reg, popped_next;
    logic                 closed_reg, closed_next;
    logic                 error_reg, error_next;
    logic                 fwd_reg;
    logic [BYTE_W-1:0]    fwd_byte_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic                 in_acc;
    logic [FUNC_W-1:0]    in_func;
    logic [BYTE_W-1:0]    in_byte;
    logic [FCNT_W-1:0]    in_count;
    cmp_t                 cap_wide;
    cmp_t                 cap_eff_wide;
    cnt_t                 cap_eff;
    cmp_t                 held_wide;
    cmp_t                 count_wide;
    cmp_t                 rp_sum;
    ptr_t                 rp_after_pop;
    ptr_t                 wp_inc;
    logic                 push_ok;
    logic                 push_err;
    logic                 pop_err;
    logic                 pop_ok;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 out_free;
    logic [BYTE_W-1:0]    front_byte;
    cnt_t                 space;
    logic [M_DATA_W-1:0]  result;

    // ------------------------------------------------------------------
    // Input decode.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_func  = s_tuser;
    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_count = s_tdata[BYTE_W+FCNT_W-1:BYTE_W];

    // The capacity register may hold more than the ring; the ring depth
    // then limits it.
    assign cap_wide     = CMP_W'(cap_reg);
    assign cap_eff_wide = (cap_wide > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_wide;
    assign cap_eff      = CNT_W'(cap_eff_wide);

    assign held_wide  = CMP_W'(held_reg);
    assign count_wide = CMP_W'(in_count);

    // A push after close is an error and comes before the full check.
    assign push_err = (in_func == FUNC_PUSH) && closed_reg;
    assign push_ok  = (in_func == FUNC_PUSH) && !closed_reg && (held_reg < cap_eff);
    // A pop beyond the held bytes is an error and changes nothing else.
    assign pop_err  = (in_func == FUNC_POP) && (count_wide > held_wide);
    assign pop_ok   = (in_func == FUNC_POP) && !pop_err && (in_count != '0);

    // Pointer arithmetic modulo the ring depth. The pop count never exceeds
    // the held count, so the sum stays below twice the depth.
    assign rp_sum       = CMP_W'(rd_ptr_reg) + count_wide;
    assign rp_after_pop = (rp_sum >= CMP_W'(DEPTH)) ? PTR_W'(rp_sum - CMP_W'(DEPTH))
                                                    : PTR_W'(rp_sum);
    assign wp_inc       = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    // ------------------------------------------------------------------
    // Next state of the FIFO.
    // ------------------------------------------------------------------
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        held_next   = held_reg;
        pushed_next = pushed_reg;
        popped_next = popped_reg;
        closed_next = closed_reg;
        error_next  = error_reg;
        if (in_acc) begin
            if (push_err || pop_err) begin
                error_next = 1'b1;
            end
            if (push_ok) begin
                wr_ptr_next = wp_inc;
                held_next   = held_reg + 1'b1;
                pushed_next = pushed_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_next = rp_after_pop;
                held_next   = held_reg - CNT_W'(in_count);
                popped_next = popped_reg + TOTAL_W'(in_count);
            end
            if (in_func == FUNC_CLOSE) begin
                closed_next = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring storage. The read at the new read pointer is issued in the same
    // cycle as the write. The two only meet when a push lands in an empty
    // ring; that byte is then forwarded from a register instead.
    // ------------------------------------------------------------------
    assign ram_we = in_acc && push_ok;

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (in_byte),
        .rd_en   (in_acc),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            fwd_reg      <= push_ok && (held_reg == '0);
            fwd_byte_reg <= in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result beat, built from the updated state.
    // ------------------------------------------------------------------
    assign front_byte = (held_reg == '0) ? '0 : (fwd_reg ? fwd_byte_reg : ram_rdata);
    assign space      = (held_reg < cap_eff) ? (cap_eff - held_reg) : '0;

    assign result = {
        (M_DATA_W - M_FIELDS_W)'(0),
        error_reg,
        closed_reg && (held_reg == '0),
        closed_reg,
        popped_reg,
        pushed_reg,
        FCNT_W'(space),
        FCNT_W'(held_reg),
        (held_reg != '0),
        front_byte
    };

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            held_reg     <= '0;
            pushed_reg   <= '0;
            popped_reg   <= '0;
            closed_reg   <= 1'b0;
            error_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            held_reg   <= held_next;
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            closed_reg <= closed_next;
            error_reg  <= error_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (state_reg == ST_LOAD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && out_free) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(held_reg) <= CMP_W'(DEPTH))
        else $error("held count exceeds the ring depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty ring with unequal pointers");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && push_ok) |=> (pushed_reg == $past(pushed_reg) + 1'b1)
                                && (held_reg == $past(held_reg) + 1'b1))
        else $error("accepted push did not advance the totals");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |=> error_reg)
        else $error("error flag cleared without reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("second beat taken while a result is being built");

endmodule

FILE: hw/rtl/bbsf_ram.sv
// ----------------------------------------------------------------------------
// bbsf_ram - generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
